// ----- rtl/core/ssd_pkg.sv -----
// Shared constants, segment encoding and the reciprocal used to divide by ten.
package ssd_pkg;

    localparam int DEFAULT_NUM_DIGITS = 8;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int SEL_W       = 3;
    localparam int SEG_W       = 8;
    localparam int QUOT_W      = 29;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/seven_segment_decimal_display_scanner_top.sv -----
// Multiplexed seven-segment display scanner with an iterative binary-to-decimal loader.
// A tick word's scan slot is registered and appears on the output the cycle after acceptance.
// Ticks may follow each other every cycle while no load converts and the output word is taken.
// A load of a nonzero number holds the input off while up to NUM_DIGITS digits are converted,
// lowest first, via ST_MUL and ST_DIG on the shared divide-by-ten multiplier; zero does not.
// Synchronous active-low reset blanks every digit, clears the overflow flag and scan position.
module seven_segment_decimal_display_scanner_top #(
    parameter int NUM_DIGITS = ssd_pkg::DEFAULT_NUM_DIGITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ssd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // value [31:0]
    input  logic                             s_axis_tuser,  // operation [0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ssd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // digit_select [2:0],
                                                            // segments [10:3],
                                                            // overflow [11], zeros [15:12]
);
    import ssd_pkg::*;

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIG
    } t_state;

    t_state                  r_state;
    logic [SEG_W-1:0]        r_codes [NUM_DIGITS];
    logic [IDX_W-1:0]        r_scan;
    logic [IDX_W-1:0]        r_pos;
    logic                    r_overflow;
    logic [31:0]             r_val;
    logic [QUOT_W-1:0]       r_quot;
    logic                    r_m_valid;
    logic [OUT_TDATA_W-1:0]  r_m_data;

    logic                    w_in_acc;
    logic [63:0]             w_prod;
    logic [31:0]             w_q10;
    logic [31:0]             w_rem;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_m_valid || m_axis_tready);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign w_prod = 64'(r_val) * 64'(RECIP_TEN);
    assign w_q10  = {r_quot, 3'b000} + {2'b00, r_quot, 1'b0};
    assign w_rem  = r_val - w_q10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_scan     <= '0;
            r_pos      <= '0;
            r_overflow <= 1'b0;
            r_m_valid  <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_codes[i] <= SEG_BLANK;
            end
        end else begin
            if (w_in_acc && s_axis_tuser == OP_TICK) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (s_axis_tuser == OP_TICK) begin
                            r_m_data  <= {4'b0000, r_overflow, r_codes[r_scan],
                                          SEL_W'(r_scan)};
                            r_scan    <= (r_scan == LAST_IDX) ? '0 : r_scan + 1'b1;
                        end else begin
                            for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                                r_codes[i] <= SEG_BLANK;
                            end
                            r_codes[LAST_IDX] <= (s_axis_tdata == '0) ? seg_encode(4'd0)
                                                                      : SEG_BLANK;
                            if (s_axis_tdata == '0) begin
                                r_overflow <= 1'b0;
                            end else begin
                                r_val   <= s_axis_tdata;
                                r_pos   <= LAST_IDX;
                                r_state <= ST_MUL;
                            end
                        end
                    end
                end
                ST_MUL: begin
                    r_quot  <= w_prod[63:RECIP_SHIFT];
                    r_state <= ST_DIG;
                end
                ST_DIG: begin
                    r_codes[r_pos] <= seg_encode(w_rem[3:0]);
                    r_val          <= 32'(r_quot);
                    if (r_quot == '0 || r_pos == '0) begin
                        r_overflow <= (r_quot != '0);
                        r_state    <= ST_IDLE;
                    end else begin
                        r_pos   <= r_pos - 1'b1;
                        r_state <= ST_MUL;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/ssd_checker.sv -----
// Port-level checks on the display scanner, bound to its top level.
module ssd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [ssd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ssd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import ssd_pkg::*;

    logic w_in_acc;
    logic w_out_idle;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_idle = !m_axis_tvalid || m_axis_tready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output word present after reset.");

    a_tick_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && s_axis_tuser == OP_TICK |=> m_axis_tvalid)
        else $error("Accepted tick produced no output word.");

    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && s_axis_tuser == OP_LOAD && w_out_idle |=> !m_axis_tvalid)
        else $error("Load produced an output word.");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && s_axis_tuser == OP_LOAD && s_axis_tdata != '0 |=> !s_axis_tready)
        else $error("Input accepted while a conversion is running.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output word changed.");

endmodule

bind seven_segment_decimal_display_scanner_top ssd_checker u_ssd_checker (.*);
